@@ sv/fqs_pkg.sv @@
// Shared types, command and status codes for the FIFO queue with search.
package fqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int WORD_BITS_DEF   = 32;

  localparam logic [3:0] CMD_PUSH     = 4'd0;
  localparam logic [3:0] CMD_POP      = 4'd1;
  localparam logic [3:0] CMD_RD_NEW   = 4'd2;
  localparam logic [3:0] CMD_RD_OLD   = 4'd3;
  localparam logic [3:0] CMD_WR_NEW   = 4'd4;
  localparam logic [3:0] CMD_WR_OLD   = 4'd5;
  localparam logic [3:0] CMD_RD_POS   = 4'd6;
  localparam logic [3:0] CMD_FIND     = 4'd7;
  localparam logic [3:0] CMD_CLEAR    = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;

  localparam logic [1:0] RK_PLAIN     = 2'd0;
  localparam logic [1:0] RK_READ      = 2'd1;
  localparam logic [1:0] RK_FOUND     = 2'd2;

  typedef struct packed {
    logic       load;
    logic       upd;
    logic       scan_init;
    logic       scan_run;
    logic       res_load;
    logic [1:0] res_kind;
    logic [2:0] res_status;
  } ctl_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       empty;
    logic       full;
    logic       pos_bad;
    logic       hit;
    logic       scan_last;
  } stat_t;

endpackage

@@ sv/fifo_queue_with_search_top.sv @@
// Top level of the FIFO queue with search: controller, datapath and checks.
//
//   channel   handshake          fields
//   command   start / busy       command, value_in, position
//   result    done (strobe)      status, value_out, found_index, entry_count
//
// An item is taken when start is high and busy is low. Push, overwrite, clear,
// unknown commands and any command refused as empty or out of range decide their
// result in the execute state; a pop or read that returns an entry passes through a
// further read state, as it waits for the registered read of the entry store.
// A find scans the queue after the execute state: the single RAM read port scans one
// entry per cycle, oldest first. Reset clears pointers and count, not the store.
// The result is shown for one cycle only; the receiver cannot hold it off.
module fifo_queue_with_search_top #(
  parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF,
  parameter int WORD_BITS   = fqs_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command,
  input  logic signed [31:0] value_in,
  input  logic [3:0]         position,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] value_out,
  output logic [3:0]         found_index,
  output logic [4:0]         entry_count
);

  fqs_pkg::ctl_t  ctl;
  fqs_pkg::stat_t stat;

  fqs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctl  (ctl),
    .busy (busy)
  );

  fqs_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .command    (command),
    .value_in   (value_in),
    .position   (position),
    .done       (done),
    .status     (status),
    .value_out  (value_out),
    .found_index(found_index),
    .entry_count(entry_count)
  );

  // A result is only strobed once the controller has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_res_strobe: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |=> done)
    else $error("loaded result was not strobed");

  // A rejected push leaves the count unchanged.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (done && status == fqs_pkg::ST_FULL) |-> $stable(entry_count))
    else $error("count changed on a rejected push");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue reported both full and empty");

endmodule

@@ sv/fqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fqs_ctrl.sv @@
// Controller state machine that sequences each queue command.
module fqs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fqs_pkg::stat_t stat,
  output fqs_pkg::ctl_t  ctl,
  output logic          busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.res_kind = fqs_pkg::RK_PLAIN;
    ctl.res_status = fqs_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (stat.cmd)
          fqs_pkg::CMD_PUSH: begin
            ctl.upd = 1'b1;
            ctl.res_load = 1'b1;
            ctl.res_status = stat.full ? fqs_pkg::ST_FULL : fqs_pkg::ST_OK;
          end
          fqs_pkg::CMD_POP, fqs_pkg::CMD_RD_NEW, fqs_pkg::CMD_RD_OLD,
          fqs_pkg::CMD_RD_POS: begin
            if (stat.empty) begin
              ctl.res_load = 1'b1;
              ctl.res_status = fqs_pkg::ST_EMPTY;
            end else if (stat.cmd == fqs_pkg::CMD_RD_POS && stat.pos_bad) begin
              ctl.res_load = 1'b1;
              ctl.res_status = fqs_pkg::ST_RANGE;
            end else begin
              // The read was issued this cycle; its data lands next cycle.
              state_next = S_READ;
            end
          end
          fqs_pkg::CMD_WR_NEW, fqs_pkg::CMD_WR_OLD: begin
            ctl.res_load = 1'b1;
            if (stat.empty) begin
              ctl.res_status = fqs_pkg::ST_EMPTY;
            end else begin
              ctl.upd = 1'b1;
            end
          end
          fqs_pkg::CMD_FIND: begin
            if (stat.empty) begin
              ctl.res_load = 1'b1;
              ctl.res_status = fqs_pkg::ST_EMPTY;
            end else begin
              ctl.scan_init = 1'b1;
              state_next = S_SCAN;
            end
          end
          fqs_pkg::CMD_CLEAR: begin
            ctl.upd = 1'b1;
            ctl.res_load = 1'b1;
          end
          default: begin
            ctl.res_load = 1'b1;
          end
        endcase
      end
      S_READ: begin
        // A pop advances the oldest pointer only after its entry was read.
        ctl.upd = 1'b1;
        ctl.res_load = 1'b1;
        ctl.res_kind = fqs_pkg::RK_READ;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan_run = 1'b1;
        if (stat.hit) begin
          ctl.res_load = 1'b1;
          ctl.res_kind = fqs_pkg::RK_FOUND;
          state_next = S_IDLE;
        end else if (stat.scan_last) begin
          ctl.res_load = 1'b1;
          ctl.res_status = fqs_pkg::ST_NOTFOUND;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/fqs_dp.sv @@
// Datapath: entry store, pointers, count, scan counters and result registers.
module fqs_dp #(
  parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF,
  parameter int WORD_BITS   = fqs_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fqs_pkg::ctl_t      ctl,
  output fqs_pkg::stat_t     stat,
  input  logic [3:0]         command,
  input  logic signed [31:0] value_in,
  input  logic [3:0]         position,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] value_out,
  output logic [3:0]         found_index,
  output logic [4:0]         entry_count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int OW = (CW > 4) ? CW : 4;
  localparam int EW = (CW > 5) ? CW : 5;

  logic [3:0]           cmd;
  logic [3:0]           pos;
  logic [WORD_BITS-1:0] word;
  logic [PW-1:0]        oldest;
  logic [PW-1:0]        newest;
  logic [CW-1:0]        held;
  logic [CW-1:0]        issue_idx;
  logic [CW-1:0]        cmp_idx;
  logic                 cmp_valid;

  logic [WORD_BITS+31:0] vin_ext;
  logic [WORD_BITS+31:0] rd_ext;
  logic [WORD_BITS-1:0]  rdata;
  logic [PW-1:0]         raddr;
  logic [PW-1:0]         waddr;
  logic                  we;
  logic [PW-1:0]         oldest_inc;
  logic [PW-1:0]         newest_inc;
  logic [PW-1:0]         newest_dec;
  logic [OW-1:0]         cmp_ext;
  logic [EW-1:0]         held_ext;

  // Slot of the entry at a given offset from the oldest; offsets stay below
  // twice the depth, so one compare and subtract wraps them.
  function automatic logic [PW-1:0] slot_at(input logic [OW-1:0] off);
    logic [OW:0] sum;
    sum = (OW+1)'(oldest) + {1'b0, off};
    if (sum >= (OW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (OW+1)'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign vin_ext = {{WORD_BITS{1'b0}}, value_in};
  assign rd_ext  = {32'b0, rdata};

  assign oldest_inc = (oldest == PW'(QUEUE_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign newest_inc = (newest == PW'(QUEUE_DEPTH - 1)) ? '0 : newest + 1'b1;
  assign newest_dec = (newest == '0) ? PW'(QUEUE_DEPTH - 1) : newest - 1'b1;

  assign stat.cmd       = cmd;
  assign stat.empty     = (held == '0);
  assign stat.full      = (held == CW'(QUEUE_DEPTH));
  assign stat.pos_bad   = (OW'(pos) >= OW'(held));
  assign stat.hit       = cmp_valid && (rdata == word);
  assign stat.scan_last = cmp_valid && (cmp_idx == held - CW'(1));

  always_comb begin
    if (ctl.scan_run) begin
      raddr = slot_at(OW'(issue_idx));
    end else begin
      case (cmd)
        fqs_pkg::CMD_RD_NEW: raddr = newest_dec;
        fqs_pkg::CMD_RD_POS: raddr = slot_at(OW'(pos));
        default:             raddr = oldest;
      endcase
    end
  end

  always_comb begin
    case (cmd)
      fqs_pkg::CMD_PUSH:   waddr = newest;
      fqs_pkg::CMD_WR_NEW: waddr = newest_dec;
      default:             waddr = oldest;
    endcase
  end

  assign we = ctl.upd && (((cmd == fqs_pkg::CMD_PUSH) && !stat.full) ||
              (((cmd == fqs_pkg::CMD_WR_NEW) || (cmd == fqs_pkg::CMD_WR_OLD)) &&
               !stat.empty));

  fqs_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(word),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      newest    <= '0;
      held      <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= ctl.res_load;
      if (ctl.upd) begin
        case (cmd)
          fqs_pkg::CMD_PUSH: begin
            if (!stat.full) begin
              newest <= newest_inc;
              held   <= held + CW'(1);
            end
          end
          fqs_pkg::CMD_POP: begin
            oldest <= oldest_inc;
            held   <= held - CW'(1);
          end
          fqs_pkg::CMD_CLEAR: begin
            oldest <= '0;
            newest <= '0;
            held   <= '0;
          end
          default: begin
          end
        endcase
      end
      cmp_valid <= ctl.scan_init || ctl.scan_run;
    end
  end

  // The first read of a find (the oldest slot) is issued in the execute state;
  // each scan cycle then issues one read and compares the last.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd  <= command;
      pos  <= position;
      word <= vin_ext[WORD_BITS-1:0];
    end
    if (ctl.scan_init) begin
      issue_idx <= CW'(1);
      cmp_idx   <= '0;
    end else if (ctl.scan_run) begin
      issue_idx <= issue_idx + CW'(1);
      cmp_idx   <= issue_idx;
    end
  end

  assign cmp_ext = OW'(cmp_idx);

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      status      <= ctl.res_status;
      value_out   <= (ctl.res_kind == fqs_pkg::RK_READ) ? $signed(rd_ext[31:0]) : '0;
      found_index <= (ctl.res_kind == fqs_pkg::RK_FOUND) ? cmp_ext[3:0] : '0;
    end
  end

  assign held_ext    = EW'(held);
  assign entry_count = held_ext[4:0];

endmodule

@@ tb/fifo_queue_with_search_top_tb.sv @@
// Self-checking testbench for the FIFO queue with search: directed table, then random items.
`timescale 1ns / 100ps

module fifo_queue_with_search_top_tb;

  localparam int QUEUE_DEPTH  = fqs_pkg::QUEUE_DEPTH_DEF;
  localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

  // Commands 9 to 15 are not defined and must leave the queue alone.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  localparam logic [1:0] MIX_FILL     = 2'd0;
  localparam logic [1:0] MIX_BALANCED = 2'd1;
  localparam logic [1:0] MIX_DRAIN    = 2'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [3:0]  found;
    logic [4:0]  count;
  } queue_result_t;

  typedef struct packed {
    logic [3:0]    cmd;
    logic [31:0]   val;
    logic [3:0]    pos;
    logic [4:0]    reps;
    logic          typed;
    queue_result_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         command = fqs_pkg::CMD_PUSH;
  logic signed [31:0] value_in = '0;
  logic [3:0]         position = '0;
  logic               done;
  logic [2:0]         status;
  logic signed [31:0] value_out;
  logic [3:0]         found_index;
  logic [4:0]         entry_count;

  fifo_queue_with_search_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .value_in    (value_in),
    .position    (position),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .found_index (found_index),
    .entry_count (entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the queue, advanced once per accepted item.
  logic [31:0]         shadow_store [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] shadow_oldest;
  logic [PTR_BITS-1:0] shadow_newest;
  logic [4:0]          shadow_count;

  queue_result_t awaited_results [$];
  plan_row_t     plan [$];

  int error_count    = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int full_seen      = 0;
  int empty_seen     = 0;
  int cycle_count    = 0;
  int burst_left     = 0;

  task automatic predict_queue_result(input logic [3:0] cmd, input logic [31:0] word,
                                      input logic [3:0] pos, output queue_result_t r);
    logic [PTR_BITS-1:0] slot;
    logic [PTR_BITS-1:0] newest_slot;
    int i;
    r = '0;
    r.status = fqs_pkg::ST_OK;
    newest_slot = shadow_newest - 1'b1;
    case (cmd)
      fqs_pkg::CMD_PUSH: begin
        if (shadow_count == QUEUE_DEPTH) begin
          r.status = fqs_pkg::ST_FULL;
        end else begin
          shadow_store[shadow_newest] = word;
          shadow_newest = shadow_newest + 1'b1;
          shadow_count = shadow_count + 1'b1;
        end
      end
      fqs_pkg::CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = fqs_pkg::ST_EMPTY;
        end else begin
          r.value = shadow_store[shadow_oldest];
          shadow_oldest = shadow_oldest + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end
      end
      fqs_pkg::CMD_RD_NEW: begin
        if (shadow_count == 0) r.status = fqs_pkg::ST_EMPTY;
        else r.value = shadow_store[newest_slot];
      end
      fqs_pkg::CMD_RD_OLD: begin
        if (shadow_count == 0) r.status = fqs_pkg::ST_EMPTY;
        else r.value = shadow_store[shadow_oldest];
      end
      fqs_pkg::CMD_WR_NEW: begin
        if (shadow_count == 0) r.status = fqs_pkg::ST_EMPTY;
        else shadow_store[newest_slot] = word;
      end
      fqs_pkg::CMD_WR_OLD: begin
        if (shadow_count == 0) r.status = fqs_pkg::ST_EMPTY;
        else shadow_store[shadow_oldest] = word;
      end
      fqs_pkg::CMD_RD_POS: begin
        slot = shadow_oldest + PTR_BITS'(pos);
        if (shadow_count == 0) r.status = fqs_pkg::ST_EMPTY;
        else if ({1'b0, pos} >= shadow_count) r.status = fqs_pkg::ST_RANGE;
        else r.value = shadow_store[slot];
      end
      fqs_pkg::CMD_FIND: begin
        if (shadow_count == 0) begin
          r.status = fqs_pkg::ST_EMPTY;
        end else begin
          r.status = fqs_pkg::ST_NOTFOUND;
          for (i = 0; i < shadow_count; i++) begin
            slot = shadow_oldest + PTR_BITS'(i);
            if (r.status == fqs_pkg::ST_NOTFOUND && shadow_store[slot] == word) begin
              r.status = fqs_pkg::ST_OK;
              r.found = 4'(i);
            end
          end
        end
      end
      fqs_pkg::CMD_CLEAR: begin
        shadow_oldest = '0;
        shadow_newest = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    r.count = shadow_count;
  endtask

  // Holds the item on the ports until the block takes it, then records what it must return.
  task automatic issue_item(input logic [3:0] cmd, input logic [31:0] val,
                            input logic [3:0] pos, input logic typed,
                            input queue_result_t want);
    queue_result_t predicted;
    start <= 1'b1;
    command <= cmd;
    value_in <= val;
    position <= pos;
    do @(posedge clk); while (!(start && !busy));
    predict_queue_result(cmd, val, pos, predicted);
    awaited_results.push_back(typed ? want : predicted);
    items_accepted++;
  endtask

  task automatic pace_sender;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic draw_random_item(input logic [1:0] mix, output logic [3:0] cmd,
                                  output logic [31:0] val, output logic [3:0] pos);
    int push_pct;
    int pop_pct;
    int roll;
    logic [PTR_BITS-1:0] slot;
    case (mix)
      MIX_FILL:     begin push_pct = 55; pop_pct = 10; end
      MIX_BALANCED: begin push_pct = 30; pop_pct = 25; end
      default:      begin push_pct = 10; pop_pct = 50; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      cmd = fqs_pkg::CMD_PUSH;
    end else if (roll < push_pct + pop_pct) begin
      cmd = fqs_pkg::CMD_POP;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = fqs_pkg::CMD_CLEAR;
      else if (roll < 10) cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else cmd = 4'($urandom_range(fqs_pkg::CMD_RD_NEW, fqs_pkg::CMD_FIND));
    end
    // Words already in the queue make finds hit and duplicates appear.
    roll = $urandom_range(0, 99);
    if (roll < 35 && shadow_count != 0) begin
      slot = shadow_oldest + PTR_BITS'($urandom_range(0, shadow_count - 1));
      val = shadow_store[slot];
    end else if (roll < 45) begin
      case ($urandom_range(0, 3))
        0:       val = 32'h0000_0000;
        1:       val = 32'hFFFF_FFFF;
        2:       val = 32'h8000_0000;
        default: val = 32'h7FFF_FFFF;
      endcase
    end else begin
      val = $urandom;
    end
    if ($urandom_range(0, 9) < 7 && shadow_count != 0) begin
      pos = 4'($urandom_range(0, shadow_count - 1));
    end else begin
      pos = 4'($urandom_range(0, 15));
    end
  endtask

  function automatic plan_row_t plan_row(input logic [3:0] cmd, input logic [31:0] val,
                                         input logic [3:0] pos, input logic [4:0] reps,
                                         input logic typed, input logic [2:0] st,
                                         input logic [31:0] rd, input logic [3:0] fi,
                                         input logic [4:0] cnt);
    plan_row_t row;
    row.cmd = cmd;
    row.val = val;
    row.pos = pos;
    row.reps = reps;
    row.typed = typed;
    row.want.status = st;
    row.want.value = rd;
    row.want.found = fi;
    row.want.count = cnt;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with none expected, expected none, actual status %h value %h",
                 $time, status, value_out);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("value_out", want.value, value_out);
        check_field("found_index", 32'(want.found), 32'(found_index));
        check_field("entry_count", 32'(want.count), 32'(entry_count));
        results_seen++;
        if (want.status == fqs_pkg::ST_FULL) full_seen++;
        if (want.status == fqs_pkg::ST_EMPTY) empty_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [3:0]  cmd;
    logic [31:0] val;
    logic [3:0]  pos;
    logic [1:0]  mix;
    int directed_items;

    shadow_oldest = '0;
    shadow_newest = '0;
    shadow_count = '0;

    //             cmd, value, pos, reps, typed, status, value_out, found, count
    plan.push_back(plan_row(fqs_pkg::CMD_POP, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_NEW, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_OLD, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_WR_NEW, 32'h11, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_WR_OLD, 32'h22, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_POS, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_FIND, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_EMPTY, 32'h0, 0, 0));
    plan.push_back(plan_row(CMD_UNUSED_HI, 32'hFFFF_FFFF, 15, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_PUSH, 32'h7FFF_FFFF, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 1));
    plan.push_back(plan_row(fqs_pkg::CMD_PUSH, 32'h8000_0000, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 2));
    plan.push_back(plan_row(fqs_pkg::CMD_PUSH, 32'hFFFF_FFFF, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_NEW, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'hFFFF_FFFF, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_OLD, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h7FFF_FFFF, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_POS, 32'h0, 1, 1, 1,
                            fqs_pkg::ST_OK, 32'h8000_0000, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_POS, 32'h0, 3, 1, 1,
                            fqs_pkg::ST_RANGE, 32'h0, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_POS, 32'h0, 15, 1, 1,
                            fqs_pkg::ST_RANGE, 32'h0, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_FIND, 32'h8000_0000, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 1, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_FIND, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_NOTFOUND, 32'h0, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_WR_NEW, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_WR_OLD, 32'h1234_5678, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_FIND, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 2, 3));
    plan.push_back(plan_row(fqs_pkg::CMD_POP, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h1234_5678, 0, 2));
    plan.push_back(plan_row(fqs_pkg::CMD_CLEAR, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_PUSH, 32'hA5A5_0000, 0, 16, 0,
                            fqs_pkg::ST_OK, 32'h0, 0, 0));
    plan.push_back(plan_row(fqs_pkg::CMD_PUSH, 32'h1, 0, 1, 1,
                            fqs_pkg::ST_FULL, 32'h0, 0, 16));
    plan.push_back(plan_row(fqs_pkg::CMD_RD_POS, 32'h0, 15, 1, 1,
                            fqs_pkg::ST_OK, 32'hA5A5_0000, 0, 16));
    plan.push_back(plan_row(CMD_UNUSED_LO, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 16));
    plan.push_back(plan_row(fqs_pkg::CMD_FIND, 32'hA5A5_0000, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 16));
    plan.push_back(plan_row(fqs_pkg::CMD_CLEAR, 32'h0, 0, 1, 1,
                            fqs_pkg::ST_OK, 32'h0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      repeat (plan[r].reps) begin
        issue_item(plan[r].cmd, plan[r].val, plan[r].pos, plan[r].typed, plan[r].want);
        pace_sender();
      end
    end
    directed_items = items_accepted;

    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) mix = 2'($urandom_range(MIX_FILL, MIX_DRAIN));
      draw_random_item(mix, cmd, val, pos);
      issue_item(cmd, val, pos, 1'b0, '0);
      pace_sender();
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d from the directed table) and %0d checked results.",
             items_accepted, directed_items, results_seen);
    $display("The queue reported full %0d times and empty %0d times.", full_seen, empty_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
